### hdl/ala_pkg.sv
package ala_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int MAX_SAMPLES = 1048576;
   localparam int LEVEL_W     = 16;

   localparam int COUNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int SQ_W    = 2 * (SAMPLE_BITS - 1) + COUNT_W;
   localparam int SUM_W   = SAMPLE_BITS + COUNT_W;
   localparam int RAD_W   = 2 * SAMPLE_BITS;
   localparam int ROOT_W  = SAMPLE_BITS;
   localparam int SREM_W  = ROOT_W + 4;
   localparam int LOOP_W  = $clog2(SQ_W);
   localparam int PC_W    = 3;

   typedef logic [SAMPLE_BITS-1:0]        mag_type;
   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [RAD_W-1:0]              rad_type;
   typedef logic [COUNT_W-1:0]            count_type;
   typedef logic [SQ_W-1:0]               sq_type;
   typedef logic signed [SUM_W-1:0]       sum_type;
   typedef logic [SUM_W-1:0]              sum_mag_type;
   typedef logic [ROOT_W-1:0]             root_type;
   typedef logic [SREM_W-1:0]             srem_type;
   typedef logic [LEVEL_W-1:0]            level_type;
   typedef logic [LOOP_W-1:0]             loop_type;
   typedef logic [PC_W-1:0]               pc_type;

   localparam count_type MAX_COUNT  = COUNT_W'(MAX_SAMPLES);
   localparam loop_type  DIV_LAST   = LOOP_W'(SQ_W - 1);
   localparam loop_type  ROOT_LAST  = LOOP_W'(ROOT_W - 1);

   // microcode step addresses
   localparam pc_type STEP_IDLE      = 3'd0;
   localparam pc_type STEP_LOAD_SQ   = 3'd1;
   localparam pc_type STEP_DIV_SQ    = 3'd2;
   localparam pc_type STEP_LOAD_ROOT = 3'd3;
   localparam pc_type STEP_ROOT      = 3'd4;
   localparam pc_type STEP_LOAD_DC   = 3'd5;
   localparam pc_type STEP_DIV_DC    = 3'd6;
   localparam pc_type STEP_EMIT      = 3'd7;

   typedef enum logic [2:0] {
      DP_NOP,
      DP_LOAD_SQ,
      DP_DIV_STEP,
      DP_LOAD_ROOT,
      DP_ROOT_STEP,
      DP_LOAD_DC,
      DP_EMIT
   } dp_op_type;

   typedef enum logic [1:0] {
      LOOP_NONE,
      LOOP_DIV,
      LOOP_ROOT
   } loop_sel_type;

   typedef enum logic [1:0] {
      JC_NEVER,
      JC_WAIT_FINAL,
      JC_LOOP,
      JC_RSP_STALL
   } jump_type;

   typedef struct packed {
      dp_op_type    op;
      loop_sel_type loop_ld;
      jump_type     jc;
      pc_type       target;
   } uword_type;

   typedef struct packed {
      dp_op_type op;
      logic      emit_go;
   } dp_ctl_type;

   function automatic uword_type ucode_rom(input pc_type pc);
      uword_type w;
      unique case (pc)
         STEP_LOAD_SQ:   w = '{DP_LOAD_SQ,   LOOP_DIV,  JC_NEVER,     STEP_IDLE};
         STEP_DIV_SQ:    w = '{DP_DIV_STEP,  LOOP_NONE, JC_LOOP,      STEP_DIV_SQ};
         STEP_LOAD_ROOT: w = '{DP_LOAD_ROOT, LOOP_ROOT, JC_NEVER,     STEP_IDLE};
         STEP_ROOT:      w = '{DP_ROOT_STEP, LOOP_NONE, JC_LOOP,      STEP_ROOT};
         STEP_LOAD_DC:   w = '{DP_LOAD_DC,   LOOP_DIV,  JC_NEVER,     STEP_IDLE};
         STEP_DIV_DC:    w = '{DP_DIV_STEP,  LOOP_NONE, JC_LOOP,      STEP_DIV_DC};
         STEP_EMIT:      w = '{DP_EMIT,      LOOP_NONE, JC_RSP_STALL, STEP_EMIT};
         default:        w = '{DP_NOP,       LOOP_NONE, JC_WAIT_FINAL, STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

### hdl/ala_if.sv
interface ala_req_if;
   logic                       valid;
   logic                       ready;
   ala_pkg::sample_type        sample;
   logic                       last;

   modport source (output valid, output sample, output last, input ready);
   modport sink (input valid, input sample, input last, output ready);
endinterface

interface ala_rsp_if;
   logic                       valid;
   logic                       ready;
   ala_pkg::level_type         rms_level;
   ala_pkg::level_type         peak_level;
   logic signed [ala_pkg::LEVEL_W-1:0] dc_level;
   logic                       overflow;

   modport source (output valid, output rms_level, output peak_level, output dc_level,
                   output overflow, input ready);
   modport sink (input valid, input rms_level, input peak_level, input dc_level,
                 input overflow, output ready);
endinterface

### hdl/ala_accum.sv
module ala_accum (
   input  logic                clock,
   input  logic                reset,
   ala_req_if.sink             req,
   input  logic                clear,
   output logic                final_item,
   output ala_pkg::sq_type     sq_sum,
   output ala_pkg::sum_type    sum,
   output ala_pkg::mag_type    peak,
   output ala_pkg::count_type  count,
   output logic                ovf
);

   logic                accept;
   logic                room;
   ala_pkg::mag_type    mag_in;
   ala_pkg::rad_type    sq_in;

   logic                a_valid_ff;
   logic                a_last_ff;
   ala_pkg::sample_type a_sample_ff;
   ala_pkg::mag_type    a_mag_ff;
   ala_pkg::rad_type    a_sq_ff;

   logic                hold_ff, hold_in;
   ala_pkg::sq_type     sq_sum_ff, sq_sum_in;
   ala_pkg::sum_type    sum_ff, sum_in;
   ala_pkg::mag_type    peak_ff, peak_in;
   ala_pkg::count_type  count_ff, count_in;
   logic                ovf_ff, ovf_in;

   assign accept     = req.valid && req.ready;
   assign req.ready  = !hold_ff;
   assign final_item = a_valid_ff && a_last_ff;
   assign room       = count_ff < ala_pkg::MAX_COUNT;

   assign sq_sum = sq_sum_ff;
   assign sum    = sum_ff;
   assign peak   = peak_ff;
   assign count  = count_ff;
   assign ovf    = ovf_ff;

   // magnitude and square of the incoming sample
   always_comb begin
      mag_in = req.sample[ala_pkg::SAMPLE_BITS-1] ? $unsigned(-req.sample)
                                                 : $unsigned(req.sample);
      sq_in  = ala_pkg::rad_type'(mag_in) * ala_pkg::rad_type'(mag_in);
   end

   always_comb begin
      sq_sum_in = sq_sum_ff;
      sum_in    = sum_ff;
      peak_in   = peak_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      hold_in   = hold_ff;
      if (clear) begin
         sq_sum_in = '0;
         sum_in    = '0;
         peak_in   = '0;
         count_in  = '0;
         ovf_in    = 1'b0;
         hold_in   = 1'b0;
      end else begin
         if (accept && req.last) begin
            hold_in = 1'b1;
         end
         if (a_valid_ff) begin
            if (room) begin
               sq_sum_in = sq_sum_ff + ala_pkg::sq_type'(a_sq_ff);
               sum_in    = sum_ff + ala_pkg::sum_type'(a_sample_ff);
               peak_in   = (a_mag_ff > peak_ff) ? a_mag_ff : peak_ff;
               count_in  = count_ff + 1'b1;
            end else begin
               ovf_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         hold_ff    <= 1'b0;
         sq_sum_ff  <= '0;
         sum_ff     <= '0;
         peak_ff    <= '0;
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
      end else begin
         a_valid_ff <= accept;
         hold_ff    <= hold_in;
         sq_sum_ff  <= sq_sum_in;
         sum_ff     <= sum_in;
         peak_ff    <= peak_in;
         count_ff   <= count_in;
         ovf_ff     <= ovf_in;
      end
      if (accept) begin
         a_last_ff   <= req.last;
         a_sample_ff <= req.sample;
         a_mag_ff    <= mag_in;
         a_sq_ff     <= sq_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ala_pkg::MAX_COUNT)
      else $error("sample count beyond run limit");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (count_ff == ala_pkg::MAX_COUNT))
      else $error("overflow flagged on a run that is not full");
`endif

endmodule

### hdl/ala_useq.sv
module ala_useq (
   input  logic                clock,
   input  logic                reset,
   input  logic                final_item,
   input  logic                rsp_stall,
   output ala_pkg::dp_ctl_type ctl
);

   ala_pkg::pc_type    pc_ff, pc_in;
   ala_pkg::loop_type  loop_ff, loop_in;
   ala_pkg::uword_type word;
   logic               take;

   assign word = ala_pkg::ucode_rom(pc_ff);

   always_comb begin
      unique case (word.jc)
         ala_pkg::JC_NEVER:      take = 1'b0;
         ala_pkg::JC_WAIT_FINAL: take = !final_item;
         ala_pkg::JC_LOOP:       take = (loop_ff != '0);
         ala_pkg::JC_RSP_STALL:  take = rsp_stall;
         default:                take = 1'b0;
      endcase
      pc_in = take ? word.target : pc_ff + 1'b1;

      loop_in = loop_ff;
      unique case (word.loop_ld)
         ala_pkg::LOOP_DIV:  loop_in = ala_pkg::DIV_LAST;
         ala_pkg::LOOP_ROOT: loop_in = ala_pkg::ROOT_LAST;
         default: begin
            if (word.jc == ala_pkg::JC_LOOP && loop_ff != '0) begin
               loop_in = loop_ff - 1'b1;
            end
         end
      endcase

      ctl.op      = word.op;
      ctl.emit_go = (word.op == ala_pkg::DP_EMIT) && !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= ala_pkg::STEP_IDLE;
         loop_ff <= '0;
      end else begin
         pc_ff   <= pc_in;
         loop_ff <= loop_in;
      end
   end

`ifndef SYNTHESIS
   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      final_item |-> (pc_ff == ala_pkg::STEP_IDLE))
      else $error("run ended while the sequencer was busy");

   a_loop_step: assert property (@(posedge clock) disable iff (reset)
      (loop_ff != '0) |-> (word.jc == ala_pkg::JC_LOOP))
      else $error("loop count live outside a loop step");

   a_emit_wrap: assert property (@(posedge clock) disable iff (reset)
      ctl.emit_go |=> (pc_ff == ala_pkg::STEP_IDLE))
      else $error("sequencer did not return to idle after emit");
`endif

endmodule

### hdl/ala_datapath.sv
module ala_datapath (
   input  logic                clock,
   input  logic                reset,
   input  ala_pkg::dp_ctl_type ctl,
   input  ala_pkg::sq_type     sq_sum,
   input  ala_pkg::sum_type    sum,
   input  ala_pkg::mag_type    peak,
   input  ala_pkg::count_type  count,
   input  logic                ovf,
   ala_rsp_if.source           rsp,
   output logic                rsp_stall
);

   // shared restoring divider
   ala_pkg::count_type   rem_ff, rem_in;
   ala_pkg::sq_type      dvd_ff, dvd_in;
   logic [ala_pkg::COUNT_W:0] div_sh;
   logic [ala_pkg::COUNT_W:0] div_diff;
   logic                 div_ge;

   // digit-by-digit square root
   ala_pkg::rad_type     rad_ff, rad_in;
   ala_pkg::srem_type    srem_ff, srem_in;
   ala_pkg::root_type    root_ff, root_in;
   ala_pkg::srem_type    rt_sh;
   ala_pkg::srem_type    rt_trial;
   ala_pkg::srem_type    rt_diff;
   logic                 rt_ge;

   logic                 neg_ff, neg_in;
   ala_pkg::sum_mag_type sum_mag;
   ala_pkg::level_type   dc_q;
   ala_pkg::level_type   dc_val;
   logic                 empty_run;

   logic                 rsp_valid_ff;
   ala_pkg::level_type   rms_ff;
   ala_pkg::level_type   peak_ff;
   ala_pkg::level_type   dc_ff;
   logic                 ovf_ff;

   always_comb begin
      div_sh   = {rem_ff, dvd_ff[ala_pkg::SQ_W-1]};
      div_ge   = div_sh >= {1'b0, count};
      div_diff = div_sh - {1'b0, count};

      rt_sh    = {srem_ff[ala_pkg::SREM_W-3:0], rad_ff[ala_pkg::RAD_W-1:ala_pkg::RAD_W-2]};
      rt_trial = {{(ala_pkg::SREM_W - ala_pkg::ROOT_W - 2){1'b0}}, root_ff, 2'b01};
      rt_ge    = rt_sh >= rt_trial;
      rt_diff  = rt_sh - rt_trial;

      sum_mag  = sum[ala_pkg::SUM_W-1] ? $unsigned(-sum) : $unsigned(sum);
      dc_q     = dvd_ff[ala_pkg::LEVEL_W-1:0];
      dc_val   = neg_ff ? (~dc_q + 1'b1) : dc_q;
      empty_run = (count == '0);

      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      rad_in  = rad_ff;
      srem_in = srem_ff;
      root_in = root_ff;
      neg_in  = neg_ff;

      unique case (ctl.op)
         ala_pkg::DP_LOAD_SQ: begin
            dvd_in = sq_sum;
            rem_in = '0;
         end
         ala_pkg::DP_DIV_STEP: begin
            rem_in = div_ge ? div_diff[ala_pkg::COUNT_W-1:0] : div_sh[ala_pkg::COUNT_W-1:0];
            dvd_in = {dvd_ff[ala_pkg::SQ_W-2:0], div_ge};
         end
         ala_pkg::DP_LOAD_ROOT: begin
            rad_in  = dvd_ff[ala_pkg::RAD_W-1:0];
            srem_in = '0;
            root_in = '0;
         end
         ala_pkg::DP_ROOT_STEP: begin
            srem_in = rt_ge ? rt_diff : rt_sh;
            root_in = {root_ff[ala_pkg::ROOT_W-2:0], rt_ge};
            rad_in  = {rad_ff[ala_pkg::RAD_W-3:0], 2'b00};
         end
         ala_pkg::DP_LOAD_DC: begin
            dvd_in = ala_pkg::sq_type'(sum_mag);
            rem_in = '0;
            neg_in = sum[ala_pkg::SUM_W-1];
         end
         default: begin
         end
      endcase
   end

   assign rsp_stall      = rsp_valid_ff && !rsp.ready;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.rms_level  = rms_ff;
   assign rsp.peak_level = peak_ff;
   assign rsp.dc_level   = $signed(dc_ff);
   assign rsp.overflow   = ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      rad_ff  <= rad_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      neg_ff  <= neg_in;
      if (ctl.emit_go) begin
         rms_ff  <= empty_run ? '0 : ala_pkg::level_type'(root_ff);
         peak_ff <= empty_run ? '0 : ala_pkg::level_type'(peak);
         dc_ff   <= empty_run ? '0 : dc_val;
         ovf_ff  <= ovf;
      end
   end

endmodule

### hdl/audio_level_analyzer_top.sv
// RMS, peak and DC level meter over runs of signed 16-bit Q1.15 samples. Samples of a run
// are taken one per clock while req_chan.ready is high; the sample marked last closes the
// run, and one transaction on rsp_chan then carries floor(sqrt(sum of squares / count)),
// the largest magnitude, the mean truncated toward zero and a flag that samples beyond
// 1048576 in the run were dropped. After the last sample, ready stays low while a small
// microcoded sequencer runs a shared bit-serial divider twice (one quotient bit per cycle over
// the 51-bit sum of squares, then over the magnitude of the signed sum) and a root unit that
// settles one result bit per cycle, and while the previous result still waits on rsp_chan.
// Samples of the next run are accepted as soon as the result is loaded into the output
// register.
module audio_level_analyzer_top (
   input  logic       clock,
   input  logic       reset,
   ala_req_if.sink    req_chan,
   ala_rsp_if.source  rsp_chan
);

   logic                final_item;
   logic                rsp_stall;
   ala_pkg::dp_ctl_type ctl;
   ala_pkg::sq_type     sq_sum;
   ala_pkg::sum_type    sum;
   ala_pkg::mag_type    peak;
   ala_pkg::count_type  count;
   logic                ovf;

   ala_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .clear      (ctl.emit_go),
      .final_item (final_item),
      .sq_sum     (sq_sum),
      .sum        (sum),
      .peak       (peak),
      .count      (count),
      .ovf        (ovf)
   );

   ala_useq u_useq (
      .clock      (clock),
      .reset      (reset),
      .final_item (final_item),
      .rsp_stall  (rsp_stall),
      .ctl        (ctl)
   );

   ala_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .sq_sum    (sq_sum),
      .sum       (sum),
      .peak      (peak),
      .count     (count),
      .ovf       (ovf),
      .rsp       (rsp_chan),
      .rsp_stall (rsp_stall)
   );

endmodule
